### hw/rtl/u8lc_pkg.sv
package u8lc_pkg;

    // Fixed width of the configuration registers and the numeric result fields
    localparam int FIELD_W = 24;

    // Input word action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Search status codes
    localparam logic [1:0] ST_SEARCHING = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TARGET_LINE   = 1'b0;
    localparam logic CFG_TARGET_COLUMN = 1'b1;

    // Byte classification masks and tags
    localparam logic [7:0] MASK_CONT  = 8'hc0;
    localparam logic [7:0] TAG_CONT   = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'he0;
    localparam logic [7:0] TAG_LEAD2  = 8'hc0;
    localparam logic [7:0] MASK_LEAD3 = 8'hf0;
    localparam logic [7:0] TAG_LEAD3  = 8'he0;
    localparam logic [7:0] MASK_LEAD4 = 8'hf8;
    localparam logic [7:0] TAG_LEAD4  = 8'hf0;
    localparam logic [7:0] BYTE_LF    = 8'h0a;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] column;
        logic [FIELD_W-1:0] position;
        logic [1:0]         search_status;
        logic [FIELD_W-1:0] found_offset;
    } t_result;

endpackage

### hw/rtl/utf8_line_utf16_column_tracker_top.sv
// Channel  | Dir | Signals                                  | Notes
// ---------+-----+------------------------------------------+---------------------------
// in       | in  | i_in_valid / o_in_ready / i_in_word      | one source byte or end
// out      | out | o_out_valid / i_out_ready / o_out_word   | one result word per input
// cfg      | in  | i_cfg_we / i_cfg_idx / i_cfg_data        | target line, target column
//
// One input word per cycle while o_in_ready is high; its result is written into the
// result register on acceptance. All per-byte work (pending flush, search compare,
// counter updates) is one combinational pass into the state and result registers.
// o_in_ready drops only while a result sits unread and i_out_ready is low.
// Synchronous active-low reset clears all counters, the search and the targets.
module utf8_line_utf16_column_tracker_top
    import u8lc_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_item              i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_result            o_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_data
);

    // Compare width: wide enough for counters, targets and one carry
    localparam int CMP_W = ((COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W) + 2;

    // Saturated counter value at compare width
    localparam logic [CMP_W-1:0] CNT_TOP = CMP_W'({COUNT_BITS{1'b1}});

    typedef logic [COUNT_BITS-1:0] t_cnt;

    // Search state threaded through the character events of one word
    typedef struct packed {
        logic [1:0] status;
        t_cnt       offset;
        t_cnt       column;
    } t_ev;

    function automatic t_cnt sat_add(t_cnt a, t_cnt b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    // One character of 'units' UTF-16 units starting at byte offset 'start'
    function automatic t_ev char_ev(t_ev ev, logic hit, logic [CMP_W-1:0] tc,
                                    t_cnt start, logic [1:0] units);
        t_ev r;
        r = ev;
        if (ev.status == ST_SEARCHING && hit) begin
            if (CMP_W'(ev.column) == tc) begin
                r.status = ST_FOUND;
                r.offset = start;
            end else if (CMP_W'(ev.column) + CMP_W'(units) > tc) begin
                r.status = ST_NOT_FOUND;
            end
        end
        r.column = sat_add(ev.column, t_cnt'(units));
        return r;
    endfunction

    // 'cnt' single-unit characters from byte offset 'start' in one step:
    // the target is hit at the byte whose column equals it
    function automatic t_ev flush_ev(t_ev ev, logic hit, logic [CMP_W-1:0] tc,
                                     t_cnt start, logic [1:0] cnt);
        t_ev              r;
        logic [CMP_W-1:0] col;
        logic [CMP_W-1:0] gap;
        r   = ev;
        col = CMP_W'(ev.column);
        gap = tc - col;
        if (cnt != 2'd0 && ev.status == ST_SEARCHING && hit) begin
            if (col > tc) begin
                r.status = ST_NOT_FOUND;
            end else if (gap < CMP_W'(cnt) && tc <= CNT_TOP) begin
                r.status = ST_FOUND;
                r.offset = sat_add(start, t_cnt'(gap));
            end
        end
        r.column = sat_add(ev.column, t_cnt'(cnt));
        return r;
    endfunction

    // End of the current line at byte offset 'at'
    function automatic t_ev line_end(t_ev ev, logic hit, logic [CMP_W-1:0] tc, t_cnt at);
        t_ev r;
        r = ev;
        if (ev.status == ST_SEARCHING && hit) begin
            if (CMP_W'(ev.column) == tc) begin
                r.status = ST_FOUND;
                r.offset = at;
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end
        return r;
    endfunction

    // Configuration
    logic [FIELD_W-1:0] r_target_line;
    logic [FIELD_W-1:0] r_target_col;

    // Tracker state
    t_cnt       r_bc, n_bc;       // byte offset
    t_cnt       r_line, n_line;   // newline count
    t_cnt       r_col, n_col;     // committed UTF-16 column
    logic [1:0] r_pend, n_pend;   // bytes of an open sequence
    logic [2:0] r_exp, n_exp;     // length announced by the lead byte
    t_cnt       r_pstart, n_pstart;
    logic [1:0] r_status, n_status;
    t_cnt       r_offset, n_offset;

    // Result register
    logic    r_out_valid;
    t_result r_out_word, n_out_word;

    logic              in_acc;
    logic              hit;
    logic [CMP_W-1:0]  tc;
    logic [2:0]        pend_inc;
    logic [7:0]        b;
    t_ev               ev;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        b        = i_in_word.data_byte;
        hit      = CMP_W'(r_line) == CMP_W'(r_target_line);
        tc       = CMP_W'(r_target_col);
        pend_inc = {1'b0, r_pend} + 3'd1;
        ev       = '{status: r_status, offset: r_offset, column: r_col};

        n_bc     = r_bc;
        n_line   = r_line;
        n_pend   = r_pend;
        n_exp    = r_exp;
        n_pstart = r_pstart;

        if (i_in_word.action == ACT_END) begin
            // flush open sequence singly, close the line, close the search
            ev     = flush_ev(ev, hit, tc, r_pstart, r_pend);
            n_pend = '0;
            n_exp  = '0;
            ev     = line_end(ev, hit, tc, r_bc);
            if (ev.status == ST_SEARCHING) begin
                ev.status = ST_NOT_FOUND;
            end
        end else begin
            n_bc = sat_add(r_bc, t_cnt'(1));
            if (r_pend != 2'd0 && (b & MASK_CONT) == TAG_CONT) begin
                if (pend_inc >= r_exp) begin
                    ev     = char_ev(ev, hit, tc, r_pstart,
                                     (r_exp == 3'd4) ? 2'd2 : 2'd1);
                    n_pend = '0;
                    n_exp  = '0;
                end else begin
                    n_pend = pend_inc[1:0];
                end
            end else begin
                // broken sequence: each pending byte is its own character
                ev     = flush_ev(ev, hit, tc, r_pstart, r_pend);
                n_pend = '0;
                n_exp  = '0;
                priority if (b == BYTE_LF) begin
                    ev        = line_end(ev, hit, tc, r_bc);
                    n_line    = sat_add(r_line, t_cnt'(1));
                    ev.column = '0;
                end else if ((b & MASK_LEAD2) == TAG_LEAD2) begin
                    n_pend   = 2'd1;
                    n_exp    = 3'd2;
                    n_pstart = r_bc;
                end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
                    n_pend   = 2'd1;
                    n_exp    = 3'd3;
                    n_pstart = r_bc;
                end else if ((b & MASK_LEAD4) == TAG_LEAD4) begin
                    n_pend   = 2'd1;
                    n_exp    = 3'd4;
                    n_pstart = r_bc;
                end else begin
                    ev = char_ev(ev, hit, tc, r_bc, 2'd1);
                end
            end
        end

        n_col    = ev.column;
        n_status = ev.status;
        n_offset = ev.offset;

        n_out_word.line          = FIELD_W'(n_line);
        n_out_word.column        = FIELD_W'(sat_add(n_col, t_cnt'(n_pend)));
        n_out_word.position      = FIELD_W'(n_bc);
        n_out_word.search_status = n_status;
        n_out_word.found_offset  = (n_status == ST_FOUND) ? FIELD_W'(n_offset) : '0;

        // end word: report, then return to the reset state
        if (i_in_word.action == ACT_END) begin
            n_bc     = '0;
            n_line   = '0;
            n_col    = '0;
            n_pstart = '0;
            n_status = ST_SEARCHING;
            n_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_line <= '0;
            r_target_col  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_LINE:   r_target_line <= i_cfg_data;
                CFG_TARGET_COLUMN: r_target_col  <= i_cfg_data;
                default:           r_target_line <= r_target_line;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc        <= '0;
            r_line      <= '0;
            r_col       <= '0;
            r_pend      <= '0;
            r_exp       <= '0;
            r_pstart    <= '0;
            r_status    <= ST_SEARCHING;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_bc        <= n_bc;
                r_line      <= n_line;
                r_col       <= n_col;
                r_pend      <= n_pend;
                r_exp       <= n_exp;
                r_pstart    <= n_pstart;
                r_status    <= n_status;
                r_offset    <= n_offset;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

### bench/tb_utf8_line_utf16_column_tracker_top.sv
`timescale 1ns / 100ps

module tb_utf8_line_utf16_column_tracker_top;
    import u8lc_pkg::*;

    localparam int unsigned SAT_MAX        = (1 << FIELD_W) - 1;
    localparam int          RANDOM_ITEMS   = 650;
    localparam int          PHASE_ITEMS    = 80;
    localparam int          LONG_HOLD      = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          REPORT_LIMIT   = 10;
    localparam int unsigned TOP            = SAT_MAX;

    // One queued input word, optionally with a hand-written expected report
    typedef struct packed {
        t_item   word;
        logic    has_lit;
        t_result lit;
    } t_stim;

    localparam t_result NO_LIT = '0;

    // Directed table, run with target line 1, column 1.
    // Line 0 holds ASCII, a 2-byte form, a 4-byte form, lone high bytes, then LF.
    // Line 1 opens with a 4-byte form straddling column 1 (lands inside the
    // surrogate pair), then a 3-byte form broken by ASCII, a 2-byte form
    // broken by LF, and a 4-byte form cut off by the end word.
    localparam int NUM_DIRECTED = 25;
    localparam t_stim DIRECTED [NUM_DIRECTED] = '{
        // end on an empty source right after reset: line 0 ends short of target
        '{'{ACT_END,  8'h00}, 1'b1, '{'0, '0, '0, ST_NOT_FOUND, '0}},
        '{'{ACT_BYTE, 8'h41}, 1'b1, '{'0, 24'd1, 24'd1, ST_SEARCHING, '0}},
        '{'{ACT_BYTE, 8'hc3}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'ha9}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'hf0}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h9f}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h98}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h80}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'hff}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h80}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'hf8}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h0a}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'hf0}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h9f}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h98}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h80}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'he2}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h82}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h41}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'hc0}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'h0a}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'hf7}, 1'b0, NO_LIT},
        '{'{ACT_BYTE, 8'hbf}, 1'b0, NO_LIT},
        '{'{ACT_END,  8'h00}, 1'b0, NO_LIT},
        // state was cleared by the previous end word
        '{'{ACT_END,  8'h00}, 1'b1, '{'0, '0, '0, ST_NOT_FOUND, '0}}
    };

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_item              i_in_word  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_result            o_out_word;
    logic               i_cfg_we   = 1'b0;
    logic               i_cfg_idx  = CFG_TARGET_LINE;
    logic [FIELD_W-1:0] i_cfg_data = '0;

    utf8_line_utf16_column_tracker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Queues between stimulus generation, the sender and the receiver
    t_stim   word_q[$];
    t_result report_q[$];

    int mismatch_count = 0;
    int random_queued  = 0;

    // Idle and pressure controls, written by the main sequence only
    bit idle_on      = 1'b1;
    bit sender_hold  = 1'b0;
    int hold_req     = 0;

    // ------------------------------------------------------------------
    // Position tracker model: own copy of the targets and the tracking state
    // ------------------------------------------------------------------
    int unsigned tgt_line = 0;
    int unsigned tgt_col  = 0;
    int unsigned bytes_seen, lines_seen, col_base;
    int unsigned pend_n, pend_len, pend_at, find_at;
    logic [1:0]  find_state;

    function automatic int unsigned sat_add(int unsigned a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > SAT_MAX) ? SAT_MAX : s;
    endfunction

    function automatic void clear_tracking();
        bytes_seen = 0;
        lines_seen = 0;
        col_base   = 0;
        pend_n     = 0;
        pend_len   = 0;
        pend_at    = 0;
        find_state = ST_SEARCHING;
        find_at    = 0;
    endfunction

    // A whole character lands at the current column: decide the lookup first
    function automatic void take_char(int unsigned at, int unsigned units);
        if (find_state == ST_SEARCHING && lines_seen == tgt_line) begin
            if (col_base == tgt_col) begin
                find_state = ST_FOUND;
                find_at    = at;
            end else if (col_base + units > tgt_col) begin
                find_state = ST_NOT_FOUND;
            end
        end
        col_base = sat_add(col_base, units);
    endfunction

    function automatic void close_line(int unsigned at);
        if (find_state == ST_SEARCHING && lines_seen == tgt_line) begin
            if (col_base == tgt_col) begin
                find_state = ST_FOUND;
                find_at    = at;
            end else begin
                find_state = ST_NOT_FOUND;
            end
        end
    endfunction

    // Broken or cut-off sequence: each pending byte is a 1-unit character
    function automatic void flush_partial();
        int unsigned k;
        for (k = 0; k < pend_n; k++) take_char(sat_add(pend_at, k), 1);
        pend_n   = 0;
        pend_len = 0;
    endfunction

    function automatic void open_seq(int unsigned at, int unsigned len);
        pend_n   = 1;
        pend_len = len;
        pend_at  = at;
    endfunction

    function automatic t_result snapshot();
        t_result r;
        r.line          = FIELD_W'(lines_seen);
        r.column        = FIELD_W'(sat_add(col_base, pend_n));
        r.position      = FIELD_W'(bytes_seen);
        r.search_status = find_state;
        r.found_offset  = (find_state == ST_FOUND) ? FIELD_W'(find_at) : '0;
        return r;
    endfunction

    function automatic t_result next_report(t_item w);
        int unsigned at;
        logic [7:0]  b;
        t_result     r;
        b = w.data_byte;
        if (w.action == ACT_END) begin
            flush_partial();
            close_line(bytes_seen);
            if (find_state == ST_SEARCHING) find_state = ST_NOT_FOUND;
            r = snapshot();
            clear_tracking();
            return r;
        end
        at = bytes_seen;
        bytes_seen = sat_add(at, 1);
        if (pend_n != 0) begin
            if ((b & MASK_CONT) == TAG_CONT) begin
                pend_n++;
                if (pend_n >= pend_len) begin
                    pend_n = 0;
                    take_char(pend_at, (pend_len == 4) ? 2 : 1);
                    pend_len = 0;
                end
                return snapshot();
            end
            flush_partial();
        end
        if (b == BYTE_LF) begin
            close_line(at);
            lines_seen = sat_add(lines_seen, 1);
            col_base   = 0;
        end else if ((b & MASK_LEAD2) == TAG_LEAD2) begin
            open_seq(at, 2);
        end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
            open_seq(at, 3);
        end else if ((b & MASK_LEAD4) == TAG_LEAD4) begin
            open_seq(at, 4);
        end else begin
            take_char(at, 1);
        end
        return snapshot();
    endfunction

    // ------------------------------------------------------------------
    // Random source text
    // ------------------------------------------------------------------
    function automatic void queue_byte(logic [7:0] b);
        t_stim s;
        s.word    = '{ACT_BYTE, b};
        s.has_lit = 1'b0;
        s.lit     = NO_LIT;
        word_q.push_back(s);
        random_queued++;
    endfunction

    function automatic void queue_end();
        t_stim s;
        s.word    = '{ACT_END, 8'($urandom_range(0, 255))};
        s.has_lit = 1'b0;
        s.lit     = NO_LIT;
        word_q.push_back(s);
        random_queued++;
    endfunction

    function automatic void queue_cont(int n);
        repeat (n) queue_byte(TAG_CONT | 8'($urandom_range(0, 63)));
    endfunction

    function automatic logic [7:0] lead_byte(int len);
        case (len)
            2:       return TAG_LEAD2 | 8'($urandom_range(0, 31));
            3:       return TAG_LEAD3 | 8'($urandom_range(0, 15));
            default: return TAG_LEAD4 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    // Mostly well-formed UTF-8, some newlines, some noise and cut sequences
    function automatic void queue_char();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 38) begin
            queue_byte(8'($urandom_range(32, 126)));
        end else if (kind < 48) begin
            queue_byte(BYTE_LF);
        end else if (kind < 82) begin
            len = $urandom_range(2, 4);
            queue_byte(lead_byte(len));
            queue_cont(len - 1);
        end else if (kind < 92) begin
            queue_byte(8'($urandom_range(0, 255)));
        end else begin
            len = $urandom_range(2, 4);
            queue_byte(lead_byte(len));
            queue_cont($urandom_range(0, len - 2));
        end
    endfunction

    // Mostly no gap, a fair share of short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Sender: the model runs on each accepted word
    // ------------------------------------------------------------------
    t_stim tx_cur;
    bit    tx_busy = 1'b0;
    int    tx_gap  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_busy = 1'b0;
            tx_gap  = 0;
            clear_tracking();
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (tx_cur.has_lit) begin
                    void'(next_report(tx_cur.word));
                    report_q.push_back(tx_cur.lit);
                end else begin
                    report_q.push_back(next_report(tx_cur.word));
                end
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (word_q.size() != 0 && !sender_hold) begin
                    tx_cur = word_q.pop_front();
                    i_in_word  <= tx_cur.word;
                    i_in_valid <= 1'b1;
                    tx_busy = 1'b1;
                    tx_gap  = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: compares each report with the oldest expected one
    // ------------------------------------------------------------------
    int rx_stall = 0;
    int hold_seen = 0;

    function automatic void check_report(t_result got);
        t_result want;
        if (report_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected report: line=%0d col=%0d pos=%0d st=%0d off=%0d",
                         got.line, got.column, got.position, got.search_status,
                         got.found_offset);
            return;
        end
        want = report_q.pop_front();
        if (got.line !== want.line || got.column !== want.column ||
            got.position !== want.position || got.search_status !== want.search_status ||
            got.found_offset !== want.found_offset) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("mismatch: want line=%0d col=%0d pos=%0d st=%0d off=%0d",
                         want.line, want.column, want.position, want.search_status,
                         want.found_offset);
                $display("          got  line=%0d col=%0d pos=%0d st=%0d off=%0d",
                         got.line, got.column, got.position, got.search_status,
                         got.found_offset);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) check_report(o_out_word);
            // long hold-off on request, so the block backs up into its input
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                rx_stall  = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any word moving on either channel
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    // Block is idle once nothing is queued, in flight or awaited
    task automatic drain();
        while (word_q.size() != 0 || tx_busy || report_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_target(input int unsigned line_no, input int unsigned col_no);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TARGET_LINE;
        i_cfg_data <= FIELD_W'(line_no);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TARGET_COLUMN;
        i_cfg_data <= FIELD_W'(col_no);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tgt_line = line_no;
        tgt_col  = col_no;
    endtask

    initial begin
        int i;
        int phase;
        int phase_stop;
        int doc_len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_target(1, 1);
        for (i = 0; i < NUM_DIRECTED; i++) word_q.push_back(DIRECTED[i]);

        for (phase = 0; random_queued < RANDOM_ITEMS; phase++) begin
            drain();
            case (phase)
                0:       set_target(0, 0);
                1:       set_target(TOP, TOP);
                2:       set_target(0, TOP);
                3:       set_target(TOP, 0);
                default: set_target($urandom_range(0, 2), $urandom_range(0, 10));
            endcase
            // every fourth phase runs flat out on both sides
            idle_on = (phase % 4) != 1;
            phase_stop = random_queued + PHASE_ITEMS;
            while (random_queued < phase_stop) begin
                doc_len = $urandom_range(3, 30);
                repeat (doc_len) queue_char();
                queue_end();
            end
            // receiver stalls for a long hold-off while the sender keeps offering words
            if (phase == 2) hold_req++;
            // sender pauses mid-phase until every report is back
            if (phase == 4) begin
                while (word_q.size() > PHASE_ITEMS / 2) @(posedge i_clk);
                sender_hold = 1'b1;
                while (report_q.size() != 0 || tx_busy) @(posedge i_clk);
                repeat (5) @(posedge i_clk);
                sender_hold = 1'b0;
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && report_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
